>>> rtl/utf8d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int CP_W        = 21;
  localparam int COUNT_OUT_W = 16;
  localparam int COUNT_WIDE_W = (COUNT_BITS > COUNT_OUT_W) ? COUNT_BITS : COUNT_OUT_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } byte_cls_t;

  typedef struct packed {
    byte_cls_t  cls;
    logic [7:0] data;
  } q_entry_t;

  function automatic logic [COUNT_OUT_W-1:0] shown_count(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_WIDE_W-1:0] w;
    w = COUNT_WIDE_W'(c);
    if (w > COUNT_WIDE_W'({COUNT_OUT_W{1'b1}})) begin
      return {COUNT_OUT_W{1'b1}};
    end
    return w[COUNT_OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/utf8_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code point decoder, one byte per item.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the queue is not full, with no gaps between
// strings. A byte is classified on entry and written to a 4-entry queue; the
// decode stage pops it once the result register is free or being read, and
// registers any result there. The queue and the result register let
// either side stall alone; input ready drops only when the queue is full.
// A code point is emitted when a 1- to 4-byte sequence completes; a zero at a
// character boundary gives an end result with the saturating character count.
// Stray continuation leads and 11111xxx leads give an error result and drop
// bytes up to the next zero; a zero inside a sequence gives an error result.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [20:0]      out_code_point,
  output logic             out_error,
  output logic             out_end_of_string,
  output logic [15:0]      out_char_count
);

  utf8d_pkg::q_entry_t q_wdata;
  utf8d_pkg::q_entry_t q_rdata;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;

  utf8d_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  utf8d_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  utf8d_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_rdata           (q_rdata),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_code_point    (out_code_point),
    .out_error         (out_error),
    .out_end_of_string (out_end_of_string),
    .out_char_count    (out_char_count)
  );

endmodule
`default_nettype wire

>>> rtl/utf8d_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_front
// Input side: accepts bytes and tags each with its lead-byte class.
// ----------------------------------------------------------------------------
module utf8d_front (
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                q_full,
  output logic                     q_push,
  output utf8d_pkg::q_entry_t      q_wdata
);

  utf8d_pkg::byte_cls_t cls;

  always_comb begin
    priority if (in_data_byte == 8'h00) begin
      cls = utf8d_pkg::CLS_ZERO;
    end else if (in_data_byte[7] == 1'b0) begin
      cls = utf8d_pkg::CLS_ASCII;
    end else if (in_data_byte[7:6] == 2'b10) begin
      cls = utf8d_pkg::CLS_CONT;
    end else if (in_data_byte[7:5] == 3'b110) begin
      cls = utf8d_pkg::CLS_LEAD2;
    end else if (in_data_byte[7:4] == 4'b1110) begin
      cls = utf8d_pkg::CLS_LEAD3;
    end else if (in_data_byte[7:3] == 5'b11110) begin
      cls = utf8d_pkg::CLS_LEAD4;
    end else begin
      cls = utf8d_pkg::CLS_BAD;
    end
  end

  assign in_ready     = !q_full;
  assign q_push       = in_valid && !q_full;
  assign q_wdata.cls  = cls;
  assign q_wdata.data = in_data_byte;

endmodule
`default_nettype wire

>>> rtl/utf8d_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_queue
// Short FIFO of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module utf8d_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire utf8d_pkg::q_entry_t wdata,
  input  wire logic                pop,
  output utf8d_pkg::q_entry_t      rdata,
  output logic                     full,
  output logic                     empty
);

  utf8d_pkg::q_entry_t                 mem_r [utf8d_pkg::QUEUE_DEPTH];
  logic [utf8d_pkg::QUEUE_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [utf8d_pkg::QUEUE_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [utf8d_pkg::QUEUE_CW-1:0]      count_r, count_nxt;

  localparam logic [utf8d_pkg::QUEUE_AW-1:0] LAST_PTR =
    utf8d_pkg::QUEUE_AW'(utf8d_pkg::QUEUE_DEPTH - 1);

  assign full  = (count_r == utf8d_pkg::QUEUE_CW'(utf8d_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= utf8d_pkg::QUEUE_CW'(utf8d_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

>>> rtl/utf8d_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_back
// Decode state machine: sequence accumulation, counting, error discard,
// and the registered result stage.
// ----------------------------------------------------------------------------
module utf8d_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire utf8d_pkg::q_entry_t q_rdata,
  input  wire logic                q_empty,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [20:0]              out_code_point,
  output logic                     out_error,
  output logic                     out_end_of_string,
  output logic [15:0]              out_char_count
);

  logic [utf8d_pkg::CP_W-1:0]       acc_r, acc_nxt;
  logic [1:0]                       due_r, due_nxt;
  logic [utf8d_pkg::COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                             disc_r, disc_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [utf8d_pkg::CP_W-1:0]       cp_r;
  logic                             err_r;
  logic                             eos_r;
  logic [utf8d_pkg::COUNT_OUT_W-1:0] cc_r;

  logic                             emit;
  logic [utf8d_pkg::CP_W-1:0]       emit_cp;
  logic                             emit_err;
  logic                             emit_eos;
  logic [utf8d_pkg::COUNT_OUT_W-1:0] emit_cc;

  logic [utf8d_pkg::COUNT_BITS-1:0] cnt_inc;
  logic [utf8d_pkg::CP_W-1:0]       acc_shift;

  assign q_pop     = !q_empty && (!out_valid_r || out_ready);
  assign cnt_inc   = (cnt_r == {utf8d_pkg::COUNT_BITS{1'b1}}) ? cnt_r : cnt_r + 1'b1;
  assign acc_shift = {acc_r[utf8d_pkg::CP_W-7:0], q_rdata.data[5:0]};

  always_comb begin
    acc_nxt  = acc_r;
    due_nxt  = due_r;
    cnt_nxt  = cnt_r;
    disc_nxt = disc_r;
    emit     = 1'b0;
    emit_cp  = '0;
    emit_err = 1'b0;
    emit_eos = 1'b0;
    emit_cc  = utf8d_pkg::shown_count(cnt_r);
    if (q_pop) begin
      if (disc_r) begin
        if (q_rdata.cls == utf8d_pkg::CLS_ZERO) begin
          disc_nxt = 1'b0;
          acc_nxt  = '0;
          due_nxt  = '0;
          cnt_nxt  = '0;
        end
      end else if (due_r == 2'd0) begin
        unique case (q_rdata.cls)
          utf8d_pkg::CLS_ZERO: begin
            emit     = 1'b1;
            emit_eos = 1'b1;
            acc_nxt  = '0;
            cnt_nxt  = '0;
          end
          utf8d_pkg::CLS_ASCII: begin
            emit    = 1'b1;
            emit_cp = utf8d_pkg::CP_W'(q_rdata.data[6:0]);
            emit_cc = utf8d_pkg::shown_count(cnt_inc);
            cnt_nxt = cnt_inc;
          end
          utf8d_pkg::CLS_LEAD2: begin
            acc_nxt = utf8d_pkg::CP_W'(q_rdata.data[4:0]);
            due_nxt = 2'd1;
          end
          utf8d_pkg::CLS_LEAD3: begin
            acc_nxt = utf8d_pkg::CP_W'(q_rdata.data[3:0]);
            due_nxt = 2'd2;
          end
          utf8d_pkg::CLS_LEAD4: begin
            acc_nxt = utf8d_pkg::CP_W'(q_rdata.data[2:0]);
            due_nxt = 2'd3;
          end
          default: begin
            emit     = 1'b1;
            emit_err = 1'b1;
            emit_eos = 1'b1;
            acc_nxt  = '0;
            cnt_nxt  = '0;
            disc_nxt = 1'b1;
          end
        endcase
      end else if (q_rdata.cls == utf8d_pkg::CLS_ZERO) begin
        // truncated sequence: terminator already seen, no discard
        emit     = 1'b1;
        emit_err = 1'b1;
        emit_eos = 1'b1;
        acc_nxt  = '0;
        due_nxt  = '0;
        cnt_nxt  = '0;
      end else begin
        due_nxt = due_r - 1'b1;
        if (due_r == 2'd1) begin
          emit    = 1'b1;
          emit_cp = acc_shift;
          emit_cc = utf8d_pkg::shown_count(cnt_inc);
          cnt_nxt = cnt_inc;
          acc_nxt = '0;
        end else begin
          acc_nxt = acc_shift;
        end
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      due_r       <= '0;
      cnt_r       <= '0;
      disc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      due_r       <= due_nxt;
      cnt_r       <= cnt_nxt;
      disc_r      <= disc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cp_r  <= emit_cp;
      err_r <= emit_err;
      eos_r <= emit_eos;
      cc_r  <= emit_cc;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_code_point    = cp_r;
  assign out_error         = err_r;
  assign out_end_of_string = eos_r;
  assign out_char_count    = cc_r;

`ifndef ASSERT_OFF
  a_disc_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> (due_r == 2'd0))
    else $error("discarding while a sequence is open");
  a_acc_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (due_r == 2'd0) |-> (acc_r == '0))
    else $error("accumulator not clear at character boundary");
  a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_err) |=> (cnt_r == '0 && due_r == 2'd0))
    else $error("error result did not clear the string state");
`endif

endmodule
`default_nettype wire
